>>> rtl/core/ost_pkg.sv
// Shared types and codes for the order-statistic set.
// Used by ost_cell, ost_tree and order_statistic_set; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ost_pkg;

    localparam int KEY_W = 32;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_DELETE = 2'd1;
    localparam logic [1:0] MODE_SELECT = 2'd2;
    localparam logic [1:0] MODE_COUNT  = 2'd3;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_RANK = 2'd1;
    localparam logic [1:0] STATUS_FULL     = 2'd2;

    typedef struct packed {
        logic              present;
        logic              found;
        logic [KEY_W-1:0]  data;
    } t_red;

    typedef struct packed {
        logic                     cmp_en;
        logic                     ins_en;
        logic                     del_en;
        logic                     sel_mode;
        logic signed [KEY_W-1:0]  value;
    } t_cell_cmd;

endpackage

`default_nettype wire

>>> rtl/core/order_statistic_set.sv
// Order-statistic set: a chain of CAPACITY key cells kept in ascending order.
// Insert and delete shift the chain by one cell; select and count read a
// registered OR tree over the cells. Depends on ost_pkg, ost_cell, ost_tree.
//
// Input channel (i_in_valid / o_in_ready) carries a word of i_mode and i_value.
// Output channel (o_out_valid / i_out_ready) carries o_answer and o_status;
// every input word gives exactly one output word, in order.
// An item passes a compare step, the reduction tree (depth L, where
// L = ceil(log4(CAPACITY)), 5 at 1024 entries) and an update step; a new
// word is accepted only once the previous one has left the update step.
// The tree depth sets the length of the reduction step.
// The output register holds a finished word while the receiver stalls; the
// next input word is still accepted and runs up to the update step, where it
// waits until the output register is free.
// Reset empties the set (key count zero); cell contents are left as they are
// and are never read above the count.
`timescale 1ns / 1ps
`default_nettype none

module order_statistic_set #(
    parameter int CAPACITY = 1024
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic [1:0]                         i_mode,
    input  wire logic signed [ost_pkg::KEY_W-1:0]   i_value,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic signed [ost_pkg::KEY_W-1:0]        o_answer,
    output logic [1:0]                              o_status
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int SEL_W = $clog2(CAPACITY);
    localparam int LVL   = ($clog2(CAPACITY) + 1) / 2;
    localparam int LVL_W = $clog2(LVL + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);
    localparam logic [LVL_W-1:0] LVL_LAST   = LVL_W'(LVL - 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CMP   = 2'd1;
    localparam logic [1:0] S_RED   = 2'd2;
    localparam logic [1:0] S_APPLY = 2'd3;

    logic [1:0]                         r_state;
    logic [1:0]                         n_state;
    logic [LVL_W-1:0]                   r_lvl;
    logic [CNT_W-1:0]                   r_count;
    logic [CNT_W-1:0]                   n_count;
    logic [1:0]                         r_mode;
    logic signed [ost_pkg::KEY_W-1:0]   r_value;
    logic [SEL_W-1:0]                   r_sel_idx;
    logic                               r_out_valid;
    logic signed [ost_pkg::KEY_W-1:0]   r_answer;
    logic [1:0]                         r_status;
    logic signed [ost_pkg::KEY_W-1:0]   n_answer;
    logic [1:0]                         n_status;

    logic                               in_take;
    logic                               slot_free;
    logic                               finish;
    logic                               full;
    logic                               rank_bad;
    logic [ost_pkg::KEY_W-1:0]          pos;
    ost_pkg::t_cell_cmd                 cmd;
    ost_pkg::t_red                      root;

    logic                               cell_lt  [CAPACITY];
    logic signed [ost_pkg::KEY_W-1:0]   cell_key [CAPACITY];
    ost_pkg::t_red                      leaf     [CAPACITY];

    assign o_in_ready = (r_state == S_IDLE);
    assign in_take    = i_in_valid && o_in_ready;
    assign slot_free  = !r_out_valid || i_out_ready;
    assign finish     = (r_state == S_APPLY) && slot_free;
    assign full       = (r_count == FULL_COUNT);
    assign pos        = root.found ? root.data : ost_pkg::KEY_W'(CAPACITY);
    assign rank_bad   = (r_value < 1) ||
                        ($unsigned(r_value) > ost_pkg::KEY_W'(r_count));

    always_comb begin
        cmd.cmp_en   = (r_state == S_CMP);
        cmd.ins_en   = finish && (r_mode == ost_pkg::MODE_INSERT) &&
                       !root.present && !full;
        cmd.del_en   = finish && (r_mode == ost_pkg::MODE_DELETE) && root.present;
        cmd.sel_mode = (r_mode == ost_pkg::MODE_SELECT);
        cmd.value    = r_value;
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic                             prev_lt;
        logic signed [ost_pkg::KEY_W-1:0] prev_key;
        logic signed [ost_pkg::KEY_W-1:0] next_key;
        if (i == 0) begin : g_first
            assign prev_lt  = 1'b1;
            assign prev_key = '0;
        end else begin : g_mid
            assign prev_lt  = cell_lt[i-1];
            assign prev_key = cell_key[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign next_key = '0;
        end else begin : g_body
            assign next_key = cell_key[i+1];
        end
        ost_cell #(
            .CAPACITY (CAPACITY),
            .IDX      (i)
        ) u_cell (
            .i_clk      (i_clk),
            .i_cmd      (cmd),
            .i_count    (r_count),
            .i_sel_idx  (r_sel_idx),
            .i_prev_lt  (prev_lt),
            .i_prev_key (prev_key),
            .i_next_key (next_key),
            .o_lt       (cell_lt[i]),
            .o_key      (cell_key[i]),
            .o_leaf     (leaf[i])
        );
    end

    ost_tree #(
        .LEAVES (CAPACITY)
    ) u_tree (
        .i_clk  (i_clk),
        .i_leaf (leaf),
        .o_root (root)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (in_take) n_state = S_CMP;
            S_CMP:   n_state = S_RED;
            S_RED:   if (r_lvl == LVL_LAST) n_state = S_APPLY;
            S_APPLY: if (slot_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_answer = '0;
        n_status = ost_pkg::STATUS_OK;
        case (r_mode)
            ost_pkg::MODE_INSERT: begin
                if (!root.present && full) n_status = ost_pkg::STATUS_FULL;
            end
            ost_pkg::MODE_SELECT: begin
                if (rank_bad) n_status = ost_pkg::STATUS_BAD_RANK;
                else          n_answer = root.data;
            end
            ost_pkg::MODE_COUNT: begin
                n_answer = pos;
            end
            default: begin
                n_answer = '0;
            end
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (cmd.ins_en)      n_count = r_count + CNT_W'(1);
        else if (cmd.del_en) n_count = r_count - CNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_lvl       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (r_state == S_RED) r_lvl <= r_lvl + LVL_W'(1);
            else                  r_lvl <= '0;
            if (finish)           r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_mode    <= i_mode;
            r_value   <= i_value;
            r_sel_idx <= SEL_W'(i_value - 32'sd1);
        end
        if (finish) begin
            r_answer <= n_answer;
            r_status <= n_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_answer    = r_answer;
    assign o_status    = r_status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("key count above capacity");

    a_ins_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.ins_en |=> r_count == CNT_W'($past(r_count) + CNT_W'(1)))
        else $error("insert did not grow the count");

    a_del_shrink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.del_en |=> r_count == CNT_W'($past(r_count) - CNT_W'(1)))
        else $error("delete did not shrink the count");

    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (finish && n_status == ost_pkg::STATUS_FULL) |-> (full && !cmd.ins_en))
        else $error("full status while space remains");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (finish && r_mode == ost_pkg::MODE_COUNT) |->
            (pos <= ost_pkg::KEY_W'(r_count)))
        else $error("count answer above key count");

endmodule

`default_nettype wire

>>> rtl/core/ost_cell.sv
// One storage cell of the sorted key chain: key, compare flags, shift logic.
// Depends on ost_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ost_cell #(
    parameter int CAPACITY = 1024,
    parameter int IDX      = 0
) (
    input  wire logic                                   i_clk,
    input  wire ost_pkg::t_cell_cmd                     i_cmd,
    input  wire logic [$clog2(CAPACITY+1)-1:0]          i_count,
    input  wire logic [$clog2(CAPACITY)-1:0]            i_sel_idx,
    input  wire logic                                   i_prev_lt,
    input  wire logic signed [ost_pkg::KEY_W-1:0]       i_prev_key,
    input  wire logic signed [ost_pkg::KEY_W-1:0]       i_next_key,
    output logic                                        o_lt,
    output logic signed [ost_pkg::KEY_W-1:0]            o_key,
    output ost_pkg::t_red                               o_leaf
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int SEL_W = $clog2(CAPACITY);
    localparam logic [CNT_W-1:0] IDX_CNT = CNT_W'(IDX);
    localparam logic [SEL_W-1:0] IDX_SEL = SEL_W'(IDX);
    localparam logic [ost_pkg::KEY_W-1:0] IDX_DATA = ost_pkg::KEY_W'(IDX);

    logic signed [ost_pkg::KEY_W-1:0] r_key;
    logic signed [ost_pkg::KEY_W-1:0] n_key;
    logic                             r_lt;
    logic                             r_eq;
    logic                             occ;
    logic                             boundary;

    assign occ      = IDX_CNT < i_count;
    assign boundary = i_prev_lt & ~r_lt;

    always_comb begin
        n_key = r_key;
        if (i_cmd.ins_en && !r_lt) begin
            n_key = i_prev_lt ? i_cmd.value : i_prev_key;
        end else if (i_cmd.del_en && !r_lt) begin
            n_key = i_next_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        if (i_cmd.cmp_en) begin
            r_lt <= occ && (r_key < i_cmd.value);
            r_eq <= occ && (r_key == i_cmd.value);
        end
    end

    always_comb begin
        o_leaf.present = r_eq;
        o_leaf.found   = boundary;
        if (i_cmd.sel_mode) begin
            o_leaf.data = (IDX_SEL == i_sel_idx) ? r_key : '0;
        end else begin
            o_leaf.data = boundary ? IDX_DATA : '0;
        end
    end

    assign o_lt  = r_lt;
    assign o_key = r_key;

endmodule

`default_nettype wire

>>> rtl/core/ost_tree.sv
// Registered OR-reduction tree, fan-in four, one register per level.
// Depends on ost_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ost_tree #(
    parameter int LEAVES = 1024
) (
    input  wire logic           i_clk,
    input  wire ost_pkg::t_red  i_leaf [LEAVES],
    output ost_pkg::t_red       o_root
);

    localparam int LVL        = ($clog2(LEAVES) + 1) / 2;
    localparam int PAD        = 1 << (2 * LVL);
    localparam int FIRST_LEAF = (PAD - 1) / 3;

    ost_pkg::t_red r_node [FIRST_LEAF];

    for (genvar j = 0; j < FIRST_LEAF; j++) begin : g_node
        ost_pkg::t_red kid [4];
        for (genvar c = 0; c < 4; c++) begin : g_kid
            localparam int CH = 4 * j + 1 + c;
            if (CH < FIRST_LEAF) begin : g_inner
                assign kid[c] = r_node[CH];
            end else if (CH - FIRST_LEAF < LEAVES) begin : g_leaf
                assign kid[c] = i_leaf[CH - FIRST_LEAF];
            end else begin : g_pad
                assign kid[c] = '0;
            end
        end
        always_ff @(posedge i_clk) begin
            r_node[j] <= ost_pkg::t_red'(kid[0] | kid[1] | kid[2] | kid[3]);
        end
    end

    assign o_root = r_node[0];

endmodule

`default_nettype wire

>>> test/ost_checker.sv
// Checker for the order-statistic set: watches both word channels, keeps its own
// sorted copy of the key set, and checks every result word in order.
// Depends on ost_pkg.
`timescale 1ns / 1ps

module ost_checker #(
    parameter int CAPACITY = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               i_in_ready,
    input  logic [1:0]                         i_mode,
    input  logic signed [ost_pkg::KEY_W-1:0]   i_value,
    input  logic                               i_out_valid,
    input  logic                               i_out_ready,
    input  logic signed [ost_pkg::KEY_W-1:0]   i_answer,
    input  logic [1:0]                         i_status,
    output int                                 o_fail_count,
    output int                                 o_pending,
    output int                                 o_checked,
    output int                                 o_full_drops,
    output int                                 o_bad_ranks
);

    localparam int KEY_W = ost_pkg::KEY_W;

    typedef struct packed {
        logic [1:0]              mode;
        logic signed [KEY_W-1:0] value;
        logic signed [KEY_W-1:0] answer;
        logic [1:0]              status;
    } t_word;

    logic signed [KEY_W-1:0] held_keys [CAPACITY];
    int                      held_count = 0;
    t_word                   awaited [$];
    int                      fails = 0;
    int                      checked = 0;
    int                      full_drops = 0;
    int                      bad_ranks = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        o_full_drops = 0;
        o_bad_ranks  = 0;
    end

    function automatic int keys_smaller(input logic signed [KEY_W-1:0] key);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = held_count;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (held_keys[mid] < key) begin
                lo = mid + 1;
            end else begin
                hi = mid;
            end
        end
        return lo;
    endfunction

    function automatic t_word apply_word(input logic [1:0] mode,
                                         input logic signed [KEY_W-1:0] value);
        t_word w;
        int    pos;
        logic  present;
        w.mode   = mode;
        w.value  = value;
        w.answer = '0;
        w.status = ost_pkg::STATUS_OK;
        pos      = keys_smaller(value);
        present  = (pos < held_count) && (held_keys[pos] == value);
        case (mode)
            ost_pkg::MODE_INSERT: begin
                if (!present) begin
                    if (held_count >= CAPACITY) begin
                        w.status = ost_pkg::STATUS_FULL;
                    end else begin
                        for (int i = held_count; i > pos; i--) begin
                            held_keys[i] = held_keys[i-1];
                        end
                        held_keys[pos] = value;
                        held_count++;
                    end
                end
            end
            ost_pkg::MODE_DELETE: begin
                if (present) begin
                    for (int i = pos; i < held_count - 1; i++) begin
                        held_keys[i] = held_keys[i+1];
                    end
                    held_count--;
                end
            end
            ost_pkg::MODE_SELECT: begin
                if (value < 1 || value > held_count) begin
                    w.status = ost_pkg::STATUS_BAD_RANK;
                end else begin
                    w.answer = held_keys[value - 1];
                end
            end
            ost_pkg::MODE_COUNT: begin
                w.answer = pos;
            end
        endcase
        return w;
    endfunction

    always @(posedge i_clk) begin : watch
        t_word want;
        if (!i_rst_n) begin
            held_count = 0;
            awaited.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (awaited.size() == 0) begin
                    fails++;
                    if (fails <= 10) begin
                        $display("%0t: result word with none pending: answer %0d status %0d",
                                 $time, i_answer, i_status);
                    end
                end else begin
                    want = awaited.pop_front();
                    checked++;
                    if (want.status == ost_pkg::STATUS_FULL) begin
                        full_drops++;
                    end
                    if (want.status == ost_pkg::STATUS_BAD_RANK) begin
                        bad_ranks++;
                    end
                    if (i_answer !== want.answer || i_status !== want.status) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("%0t: mode %0d value %0d: expected answer %0d status %0d",
                                     $time, want.mode, want.value, want.answer,
                                     want.status);
                            $display("    got answer %0d status %0d", i_answer, i_status);
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                awaited.push_back(apply_word(i_mode, i_value));
            end
        end
        o_fail_count <= fails;
        o_pending    <= awaited.size();
        o_checked    <= checked;
        o_full_drops <= full_drops;
        o_bad_ranks  <= bad_ranks;
    end

endmodule

>>> test/tb_top.sv
// Testbench top for order_statistic_set: drives directed, random and fill-to-full
// word streams with random idling on both sides; ost_checker does the checking.
// Depends on ost_pkg, ost_checker and the order_statistic_set RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int KEY_W        = ost_pkg::KEY_W;
    localparam int CAPACITY     = 1024;
    localparam int RANDOM_WORDS = 110;
    localparam int FILL_WORDS   = 1030;
    localparam int POOL_SIZE    = 40;
    localparam int STALL_LIMIT  = 2000;
    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    i_in_valid  = 1'b0;
    logic [1:0]              i_mode      = ost_pkg::MODE_INSERT;
    logic signed [KEY_W-1:0] i_value     = '0;
    logic                    i_out_ready = 1'b0;
    logic                    o_in_ready;
    logic                    o_out_valid;
    logic signed [KEY_W-1:0] o_answer;
    logic [1:0]              o_status;

    int fail_count;
    int pending;
    int checked;
    int full_drops;
    int bad_ranks;
    int words_sent   = 0;
    int stall_cycles = 0;
    bit calm         = 1'b0;

    logic signed [KEY_W-1:0] key_pool [POOL_SIZE];

    order_statistic_set #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_mode      (i_mode),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_answer    (o_answer),
        .o_status    (o_status)
    );

    ost_checker #(
        .CAPACITY(CAPACITY)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_mode       (i_mode),
        .i_value      (i_value),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_answer     (o_answer),
        .i_status     (o_status),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_full_drops (full_drops),
        .o_bad_ranks  (bad_ranks)
    );

    always #10 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_out_ready <= calm || ($urandom_range(0, 99) >= 23);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles, %0d results pending",
                     stall_cycles, pending);
            $display("** order_statistic_set: FAILED **");
            $finish;
        end
    end

    task automatic send_word(input logic [1:0] mode, input logic signed [KEY_W-1:0] value);
        while (!calm && $urandom_range(0, 99) < 23) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode     <= mode;
        i_value    <= value;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        words_sent++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
    endtask

    function automatic logic signed [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 99) < 85) begin
            return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        end
        return $urandom;
    endfunction

    function automatic logic signed [KEY_W-1:0] pick_rank();
        if ($urandom_range(0, 99) < 80) begin
            return $urandom_range(0, POOL_SIZE + 3);
        end
        return $urandom;
    endfunction

    initial begin : stimulus
        int                      pick;
        logic [KEY_W-1:0]        base;
        logic [KEY_W-1:0]        step;
        for (int i = 0; i < POOL_SIZE; i++) begin
            key_pool[i] = $urandom;
        end
        key_pool[0] = KEY_MIN;
        key_pool[1] = KEY_MAX;
        key_pool[2] = 0;
        key_pool[3] = -1;
        key_pool[4] = 1;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_word(ost_pkg::MODE_COUNT, 0);
        send_word(ost_pkg::MODE_SELECT, 1);
        send_word(ost_pkg::MODE_DELETE, 5);
        send_word(ost_pkg::MODE_INSERT, KEY_MIN);
        send_word(ost_pkg::MODE_INSERT, KEY_MAX);
        send_word(ost_pkg::MODE_INSERT, 0);
        send_word(ost_pkg::MODE_INSERT, 0);
        send_word(ost_pkg::MODE_INSERT, -1);
        send_word(ost_pkg::MODE_SELECT, 0);
        send_word(ost_pkg::MODE_SELECT, 1);
        send_word(ost_pkg::MODE_SELECT, 4);
        send_word(ost_pkg::MODE_SELECT, 5);
        send_word(ost_pkg::MODE_SELECT, -1);
        send_word(ost_pkg::MODE_SELECT, KEY_MIN);
        send_word(ost_pkg::MODE_SELECT, KEY_MAX);
        send_word(ost_pkg::MODE_COUNT, KEY_MIN);
        send_word(ost_pkg::MODE_COUNT, KEY_MAX);
        send_word(ost_pkg::MODE_COUNT, 0);
        send_word(ost_pkg::MODE_DELETE, 0);
        send_word(ost_pkg::MODE_DELETE, 0);
        send_word(ost_pkg::MODE_COUNT, 1);
        send_word(ost_pkg::MODE_DELETE, KEY_MIN);
        send_word(ost_pkg::MODE_DELETE, KEY_MAX);
        send_word(ost_pkg::MODE_DELETE, -1);
        send_word(ost_pkg::MODE_COUNT, KEY_MAX);

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == 40) begin
                wait_drained();
            end
            calm = (n >= 60 && n < 100);
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                send_word(ost_pkg::MODE_INSERT, pick_key());
            end else if (pick < 55) begin
                send_word(ost_pkg::MODE_DELETE, pick_key());
            end else if (pick < 75) begin
                send_word(ost_pkg::MODE_SELECT, pick_rank());
            end else begin
                send_word(ost_pkg::MODE_COUNT, pick_key());
            end
        end
        calm = 1'b0;

        // fill to capacity with distinct keys, then work on the full set
        wait_drained();
        step = $urandom | 32'd1;
        base = $urandom;
        for (int i = 0; i < FILL_WORDS; i++) begin
            send_word(ost_pkg::MODE_INSERT, base + i * step);
        end
        send_word(ost_pkg::MODE_INSERT, base + FILL_WORDS * step);
        send_word(ost_pkg::MODE_INSERT, base);
        send_word(ost_pkg::MODE_SELECT, CAPACITY);
        send_word(ost_pkg::MODE_SELECT, CAPACITY + 1);
        send_word(ost_pkg::MODE_SELECT, 1);
        send_word(ost_pkg::MODE_COUNT, KEY_MIN);
        send_word(ost_pkg::MODE_COUNT, KEY_MAX);
        for (int n = 0; n < 80; n++) begin
            case ($urandom_range(0, 3))
                0: send_word(ost_pkg::MODE_INSERT, $urandom);
                1: send_word(ost_pkg::MODE_DELETE,
                             base + $urandom_range(0, FILL_WORDS - 1) * step);
                2: send_word(ost_pkg::MODE_SELECT, $urandom_range(0, CAPACITY + 1));
                default: send_word(ost_pkg::MODE_COUNT, $urandom);
            endcase
        end
        send_word(ost_pkg::MODE_COUNT, KEY_MAX);
        send_word(ost_pkg::MODE_SELECT, 1);

        wait_drained();
        repeat (20) @(negedge i_clk);

        $display("covered %0d words incl. a fill to %0d keys: %0d results checked,",
                 words_sent, CAPACITY, checked);
        $display("%0d inserts refused on a full set, %0d out-of-range ranks",
                 full_drops, bad_ranks);
        if (fail_count == 0 && pending == 0) begin
            $display("** order_statistic_set: PASSED **");
        end else begin
            $display("** order_statistic_set: FAILED **");
        end
        $finish;
    end

endmodule
